>>> hw/rtl/g2n_pkg.sv
// Shared constants and tables for the geodetic to local NED converter.
package g2n_pkg;

  localparam logic signed [63:0] Q60_ONE   = 64'sd1 <<< 60;
  localparam logic signed [63:0] Q60_THREE = 64'sd3 <<< 60;
  localparam logic signed [63:0] GAIN_Q40  = 64'sd667681663043;
  localparam logic signed [63:0] SEMI_MAJOR_QMM = 64'sd25512548000;

  localparam logic [127:0] POLAR_DM   = 128'd63567523;
  localparam logic [127:0] EQUATOR_DM = 128'd63781370;
  localparam logic [127:0] RATIO_NUM  = (POLAR_DM * POLAR_DM) << 60;
  localparam logic [127:0] RATIO_Q    = RATIO_NUM / (EQUATOR_DM * EQUATOR_DM);
  // b^2/a^2 and e^2 in Q60
  localparam logic signed [63:0] RATIO_SQ_Q60 = RATIO_Q[63:0];
  localparam logic signed [63:0] ECC_SQ_Q60   = Q60_ONE - RATIO_SQ_Q60;

  // degree*1e7 to binary angle: ((|d| << 23) + half) / 7031250, done as a Q60 product
  // with 2^85 / 7031250 rounded up; the quotient sits at bit TURN_SHIFT of the product
  localparam logic [55:0] TURN_DIV  = 56'd7031250;
  localparam logic [55:0] TURN_HALF = 56'd3515625;
  localparam logic [127:0] TURN_RECIP_W =
    ((128'd1 << 85) + {72'd0, TURN_DIV} - 128'd1) / {72'd0, TURN_DIV};
  localparam logic signed [63:0] TURN_RECIP = TURN_RECIP_W[63:0];
  localparam int TURN_SHIFT = 25;
  localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;
  localparam int NEWTON_ROUNDS = 5;

  localparam logic [1:0] REG_START_X = 2'd0;
  localparam logic [1:0] REG_START_Y = 2'd1;
  localparam logic [1:0] REG_START_Z = 2'd2;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

endpackage

>>> hw/rtl/g2n_mul.sv
// Iterative Q60 multiplier: four 32x32 partial products, then round and saturate.
module g2n_mul
  import g2n_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] p
);

  logic [63:0]  ua_r, ub_r;
  logic         neg_r;
  logic [127:0] acc_r;
  logic [2:0]   k_r;
  logic         busy_r, done_r;
  logic signed [63:0] p_r;

  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh, acc_rnd;
  logic [63:0]  mag;

  always_comb begin
    ah = k_r[1] ? ua_r[63:32] : ua_r[31:0];
    bh = k_r[0] ? ub_r[63:32] : ub_r[31:0];
    pp = ah * bh;
    case ({1'b0, k_r[1]} + {1'b0, k_r[0]})
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
    acc_rnd = acc_r + (128'd1 << 59);
    mag = acc_rnd[123:60];
    if (mag[63]) begin
      mag = 64'h7FFF_FFFF_FFFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ua_r   <= a[63] ? 64'(-a) : 64'(a);
        ub_r   <= b[63] ? 64'(-b) : 64'(b);
        neg_r  <= a[63] ^ b[63];
        acc_r  <= '0;
        k_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (k_r == 3'd4) begin
          p_r    <= neg_r ? -$signed(mag) : $signed(mag);
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          acc_r <= acc_r + pp_sh;
          k_r   <= k_r + 3'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

>>> hw/rtl/g2n_cordic.sv
// Iterative rotation-mode CORDIC giving Q60 cosine and sine of a binary angle.
module g2n_cordic
  import g2n_pkg::*;
#(
  parameter int STEPS = 32,
  parameter int FRAC  = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [63:0] cs,
  output logic signed [63:0] sn
);

  localparam int SH = 40 - FRAC;
  localparam logic signed [63:0] HALF = (64'sd1 <<< SH) >>> 1;
  localparam logic signed [63:0] X0   = (GAIN_Q40 + HALF) >>> SH;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic signed [63:0] x_r, y_r, z_r;
  logic               flip_r, busy_r, done_r;
  logic [CNT_W-1:0]   cnt_r;

  logic signed [63:0] z0, dx, dy, da, xo, yo;
  logic               flip0;

  always_comb begin
    z0    = 64'($signed(angle));
    flip0 = 1'b0;
    if (z0 > (64'sd1 <<< 30)) begin
      z0    = z0 - (64'sd1 <<< 31);
      flip0 = 1'b1;
    end else if (z0 < -(64'sd1 <<< 30)) begin
      z0    = z0 + (64'sd1 <<< 31);
      flip0 = 1'b1;
    end
    dx = y_r >>> cnt_r;
    dy = x_r >>> cnt_r;
    da = (32'(cnt_r) < 32) ? $signed({32'd0, ATAN_TURNS[cnt_r[4:0]]}) : 64'sd0;
    xo = flip_r ? -x_r : x_r;
    yo = flip_r ? -y_r : y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= X0;
        y_r    <= '0;
        z_r    <= z0;
        flip_r <= flip0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - da;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + da;
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign cs   = xo <<< (60 - FRAC);
  assign sn   = yo <<< (60 - FRAC);

endmodule

>>> hw/rtl/geodetic_to_local_ned.sv
// Top level: GPS fix to local north-east-down world position, WGS84 ellipsoid.
// The arithmetic of a fix runs in turn on the shared Q60 multiplier or the shared CORDIC unit;
// in_tready is high only in idle, so a new fix is taken only once the last one has left
// the sequencer. The first fix gives no result and frees the block once it is stored as
// the reference. Reset (synchronous, active low): no reference, start registers to 0/0/178,
// idle; a result stalled at the output holds the next one back.
module geodetic_to_local_ned
  import g2n_pkg::*;
#(
  parameter int CORDIC_STEPS   = 32,
  parameter int TRIG_FRAC_BITS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // latitude_e7[30:0], longitude_e7[62:31], altitude_mm[90:63]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // world_x_mm[31:0], world_y_mm[63:32], world_z_mm[95:64]
  output logic        out_tuser,  // clipped
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  // Sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DIV_LAT = 5'd1;
  localparam logic [4:0] S_DIV_LON = 5'd2;
  localparam logic [4:0] S_COR_LAT = 5'd3;
  localparam logic [4:0] S_COR_LON = 5'd4;
  localparam logic [4:0] S_M_SS    = 5'd5;
  localparam logic [4:0] S_M_W     = 5'd6;
  localparam logic [4:0] S_N_YY    = 5'd7;
  localparam logic [4:0] S_N_WY    = 5'd8;
  localparam logic [4:0] S_N_UPD   = 5'd9;
  localparam logic [4:0] S_M_N     = 5'd10;
  localparam logic [4:0] S_M_RC    = 5'd11;
  localparam logic [4:0] S_M_E0    = 5'd12;
  localparam logic [4:0] S_M_E1    = 5'd13;
  localparam logic [4:0] S_M_NR    = 5'd14;
  localparam logic [4:0] S_M_E2    = 5'd15;
  localparam logic [4:0] S_STORE   = 5'd16;
  localparam logic [4:0] S_COR_RLA = 5'd17;
  localparam logic [4:0] S_COR_RLO = 5'd18;
  localparam logic [4:0] S_M_T0    = 5'd19;
  localparam logic [4:0] S_M_T1    = 5'd20;
  localparam logic [4:0] S_M_NO0   = 5'd21;
  localparam logic [4:0] S_M_NO1   = 5'd22;
  localparam logic [4:0] S_M_EA0   = 5'd23;
  localparam logic [4:0] S_M_EA1   = 5'd24;
  localparam logic [4:0] S_M_DN0   = 5'd25;
  localparam logic [4:0] S_M_DN1   = 5'd26;
  localparam logic [4:0] S_OUT     = 5'd27;

  logic [4:0] state_r;
  logic       op_busy_r;
  logic [2:0] nr_cnt_r;

  // Start registers
  logic signed [31:0] start_x_r, start_y_r, start_z_r;

  // Latched fix
  logic signed [31:0] lon_r;
  logic signed [27:0] alt_r;

  // Angle conversion by reciprocal multiplication on the shared multiplier
  logic [55:0] div_num_r;
  logic        div_neg_r;
  logic [31:0] la_r, lo_r;

  // Working values, all Q60 or quarter millimetres
  logic signed [63:0] cp_r, sp_r, cl_r, sl_r, w_r, y_r, n_r, rc_r, tmp_r;
  logic signed [63:0] e0_r, e1_r, e2_r, dx_r, dy_r, dz_r, t_r;
  logic signed [63:0] north_r, east_r, down_r;

  // Reference fix
  logic               have_ref_r;
  logic signed [35:0] ref_x_r, ref_y_r, ref_z_r;
  logic [31:0]        ref_lat_r, ref_lon_r;

  // Output register
  logic        out_valid_r;
  logic [95:0] out_data_r;
  logic        out_clip_r;

  // Shared units
  logic               mul_start, mul_done, mul_sel;
  logic signed [63:0] mul_a, mul_b, mul_p;
  logic               cor_start, cor_done, cor_sel;
  logic [31:0]        cor_angle;
  logic signed [63:0] cor_cs, cor_sn;

  g2n_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .p    (mul_p)
  );

  g2n_cordic #(
    .STEPS(CORDIC_STEPS),
    .FRAC (TRIG_FRAC_BITS)
  ) u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cor_start),
    .angle(cor_angle),
    .done (cor_done),
    .cs   (cor_cs),
    .sn   (cor_sn)
  );

  // Dividend: |deg| << 23 plus half the divisor
  function automatic logic [55:0] div_seed(input logic signed [32:0] v);
    logic [32:0] mag;
    mag = v[32] ? 33'(-v) : 33'(v);
    return {mag[31:0], 23'd0} + TURN_HALF;
  endfunction

  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  logic signed [30:0] in_lat, lat_clamp;
  logic signed [63:0] h_w;
  logic [31:0]        div_q, div_turns;
  logic signed [63:0] nx, ny, nz;
  logic [32:0]        sx, sy, sz;

  always_comb begin
    in_lat    = $signed(in_tdata[30:0]);
    lat_clamp = in_lat;
    if (in_lat > LAT_LIMIT) begin
      lat_clamp = LAT_LIMIT;
    end else if (in_lat < -LAT_LIMIT) begin
      lat_clamp = -LAT_LIMIT;
    end
    h_w       = 64'(alt_r) <<< 2;
    div_q     = mul_p[TURN_SHIFT+31:TURN_SHIFT];
    div_turns = div_neg_r ? 32'(-div_q) : div_q;
    // Round quarter millimetres to millimetres, then apply the start offsets
    nx = ((north_r + 64'sd2) >>> 2) + 64'(start_x_r);
    ny = 64'(start_y_r) - ((east_r + 64'sd2) >>> 2);
    nz = 64'(start_z_r) - ((down_r + 64'sd2) >>> 2);
    sx = sat32(nx);
    sy = sat32(ny);
    sz = sat32(nz);
  end

  // Operand routing for the shared multiplier and CORDIC
  always_comb begin
    mul_sel   = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    cor_sel   = 1'b0;
    cor_angle = '0;
    unique case (state_r)
      S_DIV_LAT, S_DIV_LON: begin mul_a = {8'd0, div_num_r}; mul_b = TURN_RECIP; end
      S_M_SS:    begin mul_a = sp_r;            mul_b = sp_r;                end
      S_M_W:     begin mul_a = ECC_SQ_Q60;      mul_b = tmp_r;               end
      S_N_YY:    begin mul_a = y_r;             mul_b = y_r;                 end
      S_N_WY:    begin mul_a = w_r;             mul_b = tmp_r;               end
      S_N_UPD:   begin mul_a = y_r;             mul_b = Q60_THREE - tmp_r;   end
      S_M_N:     begin mul_a = SEMI_MAJOR_QMM;  mul_b = y_r;                 end
      S_M_RC:    begin mul_a = n_r + h_w;       mul_b = cp_r;                end
      S_M_E0:    begin mul_a = rc_r;            mul_b = cl_r;                end
      S_M_E1:    begin mul_a = rc_r;            mul_b = sl_r;                end
      S_M_NR:    begin mul_a = n_r;             mul_b = RATIO_SQ_Q60;        end
      S_M_E2:    begin mul_a = tmp_r + h_w;     mul_b = sp_r;                end
      S_M_T0:    begin mul_a = cl_r;            mul_b = dx_r;                end
      S_M_T1:    begin mul_a = sl_r;            mul_b = dy_r;                end
      S_M_NO0:   begin mul_a = cp_r;            mul_b = dz_r;                end
      S_M_NO1:   begin mul_a = sp_r;            mul_b = t_r;                 end
      S_M_EA0:   begin mul_a = cl_r;            mul_b = dy_r;                end
      S_M_EA1:   begin mul_a = sl_r;            mul_b = dx_r;                end
      S_M_DN0:   begin mul_a = cp_r;            mul_b = t_r;                 end
      S_M_DN1:   begin mul_a = sp_r;            mul_b = dz_r;                end
      S_COR_LAT: begin mul_sel = 1'b0; cor_sel = 1'b1; cor_angle = la_r;      end
      S_COR_LON: begin mul_sel = 1'b0; cor_sel = 1'b1; cor_angle = lo_r;      end
      S_COR_RLA: begin mul_sel = 1'b0; cor_sel = 1'b1; cor_angle = ref_lat_r; end
      S_COR_RLO: begin mul_sel = 1'b0; cor_sel = 1'b1; cor_angle = ref_lon_r; end
      default:   mul_sel = 1'b0;
    endcase
  end

  // Issue each operation once per state; the unit's done pulse advances the sequencer
  assign mul_start = mul_sel && !op_busy_r;
  assign cor_start = cor_sel && !op_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_busy_r   <= 1'b0;
      nr_cnt_r    <= '0;
      have_ref_r  <= 1'b0;
      ref_x_r     <= '0;
      ref_y_r     <= '0;
      ref_z_r     <= '0;
      ref_lat_r   <= '0;
      ref_lon_r   <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      start_z_r   <= 32'sd178;
      out_valid_r <= 1'b0;
    end else begin
      // Configuration writes land in any state; indexes past the list are dropped
      if (cfg_we) begin
        case (cfg_addr)
          REG_START_X: start_x_r <= $signed(cfg_wdata);
          REG_START_Y: start_y_r <= $signed(cfg_wdata);
          REG_START_Z: start_z_r <= $signed(cfg_wdata);
          default:     ;
        endcase
      end

      // Drain the output register; a result ready in S_OUT refills it instead
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      if (mul_start || cor_start) begin
        op_busy_r <= 1'b1;
      end
      if (mul_done || cor_done) begin
        op_busy_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            lon_r     <= $signed(in_tdata[62:31]);
            alt_r     <= $signed(in_tdata[90:63]);
            div_num_r <= div_seed(33'(lat_clamp));
            div_neg_r <= lat_clamp[30];
            state_r   <= S_DIV_LAT;
          end
        end
        S_DIV_LAT: if (mul_done) begin
          la_r      <= div_turns;
          div_num_r <= div_seed(33'(lon_r));
          div_neg_r <= lon_r[31];
          state_r   <= S_DIV_LON;
        end
        S_DIV_LON: if (mul_done) begin
          lo_r    <= div_turns;
          state_r <= S_COR_LAT;
        end
        S_COR_LAT: if (cor_done) begin
          cp_r <= cor_cs; sp_r <= cor_sn; state_r <= S_COR_LON;
        end
        S_COR_LON: if (cor_done) begin
          cl_r <= cor_cs; sl_r <= cor_sn; state_r <= S_M_SS;
        end
        S_M_SS: if (mul_done) begin
          tmp_r <= mul_p; state_r <= S_M_W;
        end
        S_M_W: if (mul_done) begin
          w_r      <= Q60_ONE - mul_p;
          y_r      <= Q60_ONE;
          nr_cnt_r <= '0;
          state_r  <= S_N_YY;
        end
        S_N_YY: if (mul_done) begin
          tmp_r <= mul_p; state_r <= S_N_WY;
        end
        S_N_WY: if (mul_done) begin
          tmp_r <= mul_p; state_r <= S_N_UPD;
        end
        S_N_UPD: if (mul_done) begin
          // Newton step for 1/sqrt(w), halving by arithmetic shift
          y_r      <= mul_p >>> 1;
          nr_cnt_r <= nr_cnt_r + 3'd1;
          state_r  <= (nr_cnt_r == 3'(NEWTON_ROUNDS - 1)) ? S_M_N : S_N_YY;
        end
        S_M_N: if (mul_done) begin
          n_r <= mul_p; state_r <= S_M_RC;
        end
        S_M_RC: if (mul_done) begin
          rc_r <= mul_p; state_r <= S_M_E0;
        end
        S_M_E0: if (mul_done) begin
          e0_r <= mul_p; state_r <= S_M_E1;
        end
        S_M_E1: if (mul_done) begin
          e1_r <= mul_p; state_r <= S_M_NR;
        end
        S_M_NR: if (mul_done) begin
          tmp_r <= mul_p; state_r <= S_M_E2;
        end
        S_M_E2: if (mul_done) begin
          e2_r <= mul_p; state_r <= S_STORE;
        end
        S_STORE: begin
          if (!have_ref_r) begin
            // First fix becomes the reference and yields no transaction
            ref_x_r    <= e0_r[35:0];
            ref_y_r    <= e1_r[35:0];
            ref_z_r    <= e2_r[35:0];
            ref_lat_r  <= la_r;
            ref_lon_r  <= lo_r;
            have_ref_r <= 1'b1;
            state_r    <= S_IDLE;
          end else begin
            dx_r    <= e0_r - 64'(ref_x_r);
            dy_r    <= e1_r - 64'(ref_y_r);
            dz_r    <= e2_r - 64'(ref_z_r);
            state_r <= S_COR_RLA;
          end
        end
        S_COR_RLA: if (cor_done) begin
          cp_r <= cor_cs; sp_r <= cor_sn; state_r <= S_COR_RLO;
        end
        S_COR_RLO: if (cor_done) begin
          cl_r <= cor_cs; sl_r <= cor_sn; state_r <= S_M_T0;
        end
        S_M_T0: if (mul_done) begin
          t_r <= mul_p; state_r <= S_M_T1;
        end
        S_M_T1: if (mul_done) begin
          t_r <= t_r + mul_p; state_r <= S_M_NO0;
        end
        S_M_NO0: if (mul_done) begin
          north_r <= mul_p; state_r <= S_M_NO1;
        end
        S_M_NO1: if (mul_done) begin
          north_r <= north_r - mul_p; state_r <= S_M_EA0;
        end
        S_M_EA0: if (mul_done) begin
          east_r <= mul_p; state_r <= S_M_EA1;
        end
        S_M_EA1: if (mul_done) begin
          east_r <= east_r - mul_p; state_r <= S_M_DN0;
        end
        S_M_DN0: if (mul_done) begin
          down_r <= -mul_p; state_r <= S_M_DN1;
        end
        S_M_DN1: if (mul_done) begin
          down_r <= down_r - mul_p; state_r <= S_OUT;
        end
        S_OUT: begin
          // Hold until the output register is free or being drained
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {sz[31:0], sy[31:0], sx[31:0]};
            out_clip_r  <= sx[32] | sy[32] | sz[32];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

endmodule

>>> hw/rtl/g2n_checker.sv
// Port-level checks for the geodetic to local NED converter, bound to the top level.
module g2n_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // An accepted fix keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while converting");

  // A clipped result has at least one coordinate at a 32-bit limit
  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[31:0] == 32'h7FFF_FFFF || out_tdata[31:0] == 32'h8000_0000 ||
      out_tdata[63:32] == 32'h7FFF_FFFF || out_tdata[63:32] == 32'h8000_0000 ||
      out_tdata[95:64] == 32'h7FFF_FFFF || out_tdata[95:64] == 32'h8000_0000)
    else $error("clipped flag without a saturated coordinate");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind geodetic_to_local_ned g2n_checker u_g2n_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for the geodetic fix to local NED world position converter.
`timescale 1ns / 100ps

module tb_top;
  import g2n_pkg::*;

  typedef logic signed [63:0] s64_t;

  // Packed with latitude in the lowest bits, as on in_tdata
  typedef struct packed {
    logic [27:0] alt;
    logic [31:0] lon;
    logic [30:0] lat;
  } fix_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        clip;
  } world_pos_t;

  localparam int STEPS     = 32;
  localparam int TRIG_FRAC = 30;
  // Index past the last start register: the block must ignore it
  localparam logic [1:0] REG_NONE = 2'd3;
  // Margin for the last fix to finish before idle-only actions
  localparam int SETTLE_CYCLES = 700;
  localparam int CYCLE_LIMIT   = 3000000;

  // Home position for well-formed tracks: first fix becomes the reference
  localparam int HOME_LAT = 473977420;
  localparam int HOME_LON = 85455940;
  localparam int HOME_ALT = 488000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // latitude_e7[30:0], longitude_e7[62:31], altitude_mm[90:63]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;       // world_x_mm[31:0], world_y_mm[63:32], world_z_mm[95:64]
  logic        out_tuser;       // clipped
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  fix_t       pending_fixes[$];
  world_pos_t expected_positions[$];
  int         errors = 0;
  int         cycle_count = 0;
  bit         quiet = 1'b0;
  int         send_gap = 0;
  int         recv_stall = 0;

  // Mirror of the block's state and start registers
  bit          have_home;
  s64_t        home_ecef[3];
  logic [31:0] home_lat_bam, home_lon_bam;
  s64_t        start_x, start_y, start_z;

  geodetic_to_local_ned DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Q60 product, rounded half away from zero, bits 123:60 kept, magnitude saturated
  function automatic s64_t q60_mul(s64_t a, s64_t b);
    logic         neg;
    logic [63:0]  ua, ub, mag;
    logic [127:0] prod;
    neg  = a[63] ^ b[63];
    ua   = a[63] ? ~a + 64'd1 : a;
    ub   = b[63] ? ~b + 64'd1 : b;
    prod = {64'd0, ua} * {64'd0, ub} + (128'd1 << 59);
    mag  = prod[123:60];
    if (mag[63])
      mag = 64'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -s64_t'(mag) : s64_t'(mag);
  endfunction

  // Degrees * 1e7 to binary angle, rounded half away from zero
  function automatic logic [31:0] deg_to_bam(s64_t deg);
    logic [63:0] mag, q;
    mag = (deg < 0 ? -deg : deg) << 23;
    q   = (mag + 64'd3515625) / 64'd7031250;
    return deg < 0 ? 32'(-q) : q[31:0];
  endfunction

  // Folded CORDIC sine and cosine, widened to Q60
  task automatic bam_sincos(input logic [31:0] ang, output s64_t cs, output s64_t sn);
    s64_t z, x, y, dx, dy, da;
    bit   flip;
    z = s64_t'({32'd0, ang});
    flip = 1'b0;
    if (z >= (64'sd1 <<< 31))
      z -= 64'sd1 <<< 32;
    if (z > (64'sd1 <<< 30)) begin
      z -= 64'sd1 <<< 31;
      flip = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += 64'sd1 <<< 31;
      flip = 1'b1;
    end
    x = GAIN_Q40;
    if (TRIG_FRAC < 40)
      x = (GAIN_Q40 + (64'sd1 <<< (39 - TRIG_FRAC))) >>> (40 - TRIG_FRAC);
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      da = i < 32 ? s64_t'({32'd0, ATAN_TURNS[i]}) : 64'sd0;
      if (z >= 0) begin
        x -= dx; y += dy; z -= da;
      end else begin
        x += dx; y -= dy; z += da;
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cs = x <<< (60 - TRIG_FRAC);
    sn = y <<< (60 - TRIG_FRAC);
  endtask

  // Earth-centred position in quarter millimetres
  task automatic fix_to_ecef(input logic [31:0] lat, input logic [31:0] lon,
                             input s64_t alt, output s64_t p[3]);
    s64_t cp, sp, cl, sl, w, y, n, h, rc;
    bam_sincos(lat, cp, sp);
    bam_sincos(lon, cl, sl);
    w = Q60_ONE - q60_mul(ECC_SQ_Q60, q60_mul(sp, sp));
    y = Q60_ONE;
    for (int k = 0; k < NEWTON_ROUNDS; k++)
      y = q60_mul(y, Q60_THREE - q60_mul(w, q60_mul(y, y))) >>> 1;
    n = q60_mul(SEMI_MAJOR_QMM, y);
    h = alt * 4;
    rc = q60_mul(n + h, cp);
    p[0] = q60_mul(rc, cl);
    p[1] = q60_mul(rc, sl);
    p[2] = q60_mul(q60_mul(n, RATIO_SQ_Q60) + h, sp);
  endtask

  function automatic logic [31:0] clamp32(s64_t v, inout logic clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Track one accepted fix: store it as home or queue its world position
  task automatic predict_world_pos(input fix_t f);
    s64_t        lat, e[3], dx, dy, dz, cp, sp, cl, sl, t, north, east, down;
    logic [31:0] la, lo;
    world_pos_t  wp;
    lat = s64_t'(signed'(f.lat));
    if (lat > 64'sd900000000) lat = 64'sd900000000;
    if (lat < -64'sd900000000) lat = -64'sd900000000;
    la = deg_to_bam(lat);
    lo = deg_to_bam(s64_t'(signed'(f.lon)));
    fix_to_ecef(la, lo, s64_t'(signed'(f.alt)), e);
    if (!have_home) begin
      home_ecef = e;
      home_lat_bam = la;
      home_lon_bam = lo;
      have_home = 1'b1;
      return;
    end
    dx = e[0] - home_ecef[0];
    dy = e[1] - home_ecef[1];
    dz = e[2] - home_ecef[2];
    bam_sincos(home_lat_bam, cp, sp);
    bam_sincos(home_lon_bam, cl, sl);
    t = q60_mul(cl, dx) + q60_mul(sl, dy);
    north = q60_mul(cp, dz) - q60_mul(sp, t);
    east = q60_mul(cl, dy) - q60_mul(sl, dx);
    down = -q60_mul(cp, t) - q60_mul(sp, dz);
    wp.clip = 1'b0;
    wp.x = clamp32(((north + 2) >>> 2) + start_x, wp.clip);
    wp.y = clamp32(start_y - ((east + 2) >>> 2), wp.clip);
    wp.z = clamp32(start_z - ((down + 2) >>> 2), wp.clip);
    expected_positions.insert(expected_positions.size(), wp);
  endtask

  // Driver: advance to the next pending fix once the current transaction completes
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid)
        predict_world_pos(fix_t'(in_tdata[90:0]));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_fixes.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {5'd0, pending_fixes.pop_front()};
        if (!quiet && $urandom_range(0, 3) == 0)
          send_gap <= $urandom_range(1, 9);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: stall in bursts, compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_positions.size() == 0) begin
          $display("%0t: unexpected result %h clip %b", $time, out_tdata, out_tuser);
          errors++;
        end else begin
          world_pos_t wp;
          wp = expected_positions.pop_front();
          if (out_tdata[31:0] !== wp.x) begin
            $display("%0t: world_x_mm expected %0d actual %0d", $time,
                     signed'(wp.x), signed'(out_tdata[31:0]));
            errors++;
          end
          if (out_tdata[63:32] !== wp.y) begin
            $display("%0t: world_y_mm expected %0d actual %0d", $time,
                     signed'(wp.y), signed'(out_tdata[63:32]));
            errors++;
          end
          if (out_tdata[95:64] !== wp.z) begin
            $display("%0t: world_z_mm expected %0d actual %0d", $time,
                     signed'(wp.z), signed'(out_tdata[95:64]));
            errors++;
          end
          if (out_tuser !== wp.clip) begin
            $display("%0t: clipped expected %b actual %b", $time, wp.clip, out_tuser);
            errors++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0)
          recv_stall <= $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic add_fix(input int lat, input int lon, input int alt);
    fix_t f;
    f.lat = lat[30:0];
    f.lon = lon;
    f.alt = alt[27:0];
    pending_fixes.insert(pending_fixes.size(), f);
  endtask

  // Mostly tracks around home with random content, some far jumps and raw noise
  task automatic add_random_fixes(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)
        add_fix(HOME_LAT + int'($urandom_range(0, 4000000)) - 2000000,
                HOME_LON + int'($urandom_range(0, 4000000)) - 2000000,
                HOME_ALT + int'($urandom_range(0, 2000000)) - 1000000);
      else if (pick < 8)
        add_fix(int'($urandom_range(0, 1800000000)) - 900000000,
                int'($urandom_range(0, 2000000000)) - 1000000000,
                int'($urandom_range(0, 101000000)) - 1000000);
      else
        add_fix($urandom, $urandom, $urandom);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_START_X: start_x = s64_t'(signed'(data));
      REG_START_Y: start_y = s64_t'(signed'(data));
      REG_START_Z: start_z = s64_t'(signed'(data));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_starts(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
    write_reg(REG_START_X, x);
    write_reg(REG_START_Y, y);
    write_reg(REG_START_Z, z);
  endtask

  // Hold until every fix is taken and every result has arrived, then let the block settle
  task automatic wait_idle();
    wait (pending_fixes.size() == 0 && !in_tvalid);
    wait (expected_positions.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    wait (expected_positions.size() == 0);
  endtask

  initial begin
    have_home = 1'b0;
    start_x = 0;
    start_y = 0;
    start_z = 178;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: home fix first, then field extremes and the special cases
    add_fix(HOME_LAT, HOME_LON, HOME_ALT);
    add_fix(HOME_LAT, HOME_LON, HOME_ALT);
    add_fix(HOME_LAT + 10, HOME_LON - 10, HOME_ALT + 1);
    add_fix(900000000, 0, 0);
    add_fix(-900000000, 0, 0);
    add_fix(1073741823, HOME_LON, HOME_ALT);      // latitude past the pole, saturated
    add_fix(-1073741824, HOME_LON, HOME_ALT);
    add_fix(900000001, HOME_LON, HOME_ALT);
    add_fix(HOME_LAT, 1800000000, HOME_ALT);
    add_fix(HOME_LAT, -1800000000, HOME_ALT);
    add_fix(HOME_LAT, 2147483647, HOME_ALT);      // longitude wraps a full turn
    add_fix(HOME_LAT, -2147483648, HOME_ALT);
    add_fix(HOME_LAT, int'(HOME_LON + 64'sd3600000000), HOME_ALT);
    add_fix(HOME_LAT, HOME_LON, -1000000);
    add_fix(HOME_LAT, HOME_LON, 100000000);
    add_fix(HOME_LAT, HOME_LON, 134217727);       // altitude beyond its stated range
    add_fix(HOME_LAT, HOME_LON, -134217728);
    add_fix(0, 0, 0);
    add_fix(-1, -1, -1);
    add_fix(450000000, 900000000, 0);
    wait_idle();

    // Output overflow both ways, then zero, random and an ignored index
    write_starts(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_fix(HOME_LAT, HOME_LON, HOME_ALT);
    add_random_fixes(260);
    wait_idle();
    write_starts(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_fix(HOME_LAT, HOME_LON, HOME_ALT);
    add_random_fixes(260);
    wait_idle();
    write_starts(32'd0, 32'd0, 32'd0);
    add_random_fixes(260);
    wait_idle();
    write_starts($urandom, $urandom, $urandom);
    add_random_fixes(260);
    wait_idle();
    write_reg(REG_NONE, $urandom);
    quiet = 1'b1;
    add_random_fixes(200);
    wait_idle();

    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/g2n_pkg.sv
hw/rtl/g2n_mul.sv
hw/rtl/g2n_cordic.sv
hw/rtl/geodetic_to_local_ned.sv
hw/rtl/g2n_checker.sv
sim/tb_top.sv
